>>> hdl/ps2_set1_scancode_to_key_assert.svh
// ----------------------------------------------------------------------------
// PS/2 set 1 decoder assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PS2_SET1_SCANCODE_TO_KEY_ASSERT_SVH
`define PS2_SET1_SCANCODE_TO_KEY_ASSERT_SVH

`ifndef SYNTHESIS
`define PS2S1_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2s1 assertion failed");
`define PS2S1_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2s1 assertion failed");
`else
`define PS2S1_ASSERT_IMPLY(label, ante, cons)
`define PS2S1_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hdl/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 set 1 decoder package
// Key kind codes, scan code constants and the US layout tables.
// ----------------------------------------------------------------------------
package ps2s1_pkg;

  localparam int KIND_W = 4;
  localparam int CHAR_W = 7;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 4'd0,
    KIND_CHAR  = 4'd1,
    KIND_UP    = 4'd2,
    KIND_DOWN  = 4'd3,
    KIND_LEFT  = 4'd4,
    KIND_RIGHT = 4'd5,
    KIND_HOME  = 4'd6,
    KIND_END   = 4'd7,
    KIND_PGUP  = 4'd8,
    KIND_PGDN  = 4'd9,
    KIND_DEL   = 4'd10,
    KIND_INS   = 4'd11,
    KIND_F1    = 4'd12,
    KIND_F2    = 4'd13,
    KIND_CTRLC = 4'd14
  } key_kind_t;

  localparam logic [BYTE_W-1:0] SC_PREFIX    = 8'hE0;
  localparam logic [BYTE_W-1:0] SC_LSHIFT_MK = 8'h2A;
  localparam logic [BYTE_W-1:0] SC_RSHIFT_MK = 8'h36;
  localparam logic [BYTE_W-1:0] SC_LSHIFT_BR = 8'hAA;
  localparam logic [BYTE_W-1:0] SC_RSHIFT_BR = 8'hB6;
  localparam logic [BYTE_W-1:0] SC_CTRL_MK   = 8'h1D;
  localparam logic [BYTE_W-1:0] SC_CTRL_BR   = 8'h9D;
  localparam logic [BYTE_W-1:0] SC_F1_MK     = 8'h3B;
  localparam logic [BYTE_W-1:0] SC_F2_MK     = 8'h3C;
  localparam logic [BYTE_W-1:0] SC_TABLE_LEN = 8'd59;
  localparam int                REL_BIT      = 7;
  localparam logic [CHAR_W-1:0] ASCII_LC_C   = 7'h63;

  function automatic key_kind_t nav_kind(input logic [BYTE_W-1:0] code);
    key_kind_t k;
    case (code)
      8'h48:   k = KIND_UP;
      8'h50:   k = KIND_DOWN;
      8'h4B:   k = KIND_LEFT;
      8'h4D:   k = KIND_RIGHT;
      8'h47:   k = KIND_HOME;
      8'h4F:   k = KIND_END;
      8'h49:   k = KIND_PGUP;
      8'h51:   k = KIND_PGDN;
      8'h53:   k = KIND_DEL;
      8'h52:   k = KIND_INS;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
      6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
      6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;  6'd17: c = 7'h77;
      6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;  6'd21: c = 7'h79;
      6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6F;  6'd25: c = 7'h70;
      6'd26: c = 7'h5B;  6'd27: c = 7'h5D;  6'd28: c = 7'h0A;  6'd30: c = 7'h61;
      6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;  6'd34: c = 7'h67;
      6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;  6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;  6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;  6'd47: c = 7'h76;
      6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;  6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;  6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_char(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
      6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;  6'd17: c = 7'h57;
      6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;  6'd21: c = 7'h59;
      6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4F;  6'd25: c = 7'h50;
      6'd26: c = 7'h7B;  6'd27: c = 7'h7D;  6'd28: c = 7'h0A;  6'd30: c = 7'h41;
      6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;  6'd34: c = 7'h47;
      6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;  6'd38: c = 7'h4C;
      6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;  6'd43: c = 7'h7C;
      6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;  6'd47: c = 7'h56;
      6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;  6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;  6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/ps2_set1_scancode_to_key.sv
// ----------------------------------------------------------------------------
// PS/2 set 1 scan code to key decoder
// Turns keyboard set 1 bytes into key events with a US layout.
// ----------------------------------------------------------------------------
// Takes one scan code word per clock and returns one key word for each, in
// order; throughput is one word per cycle while out_ready is high. A word
// passes an input register and then a result register, which holds its key
// word until it is taken. The shift, ctrl and extended prefix flags are
// updated as a word moves from the input register into the result register,
// and ctrl_down reports the ctrl flag after that word.
// ----------------------------------------------------------------------------
`include "ps2_set1_scancode_to_key_assert.svh"

module ps2_set1_scancode_to_key (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ps2s1_pkg::BYTE_W-1:0]    scan_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ps2s1_pkg::KIND_W-1:0]    key_kind,
  output logic [ps2s1_pkg::CHAR_W-1:0]    char_code,
  output logic                            ctrl_down
);
  import ps2s1_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_adv;

  logic shift_held, shift_held_next;
  logic ctrl_held, ctrl_held_next;
  logic prefix_pending, prefix_pending_next;

  key_kind_t         kind_next;
  logic [CHAR_W-1:0] char_next;
  logic [CHAR_W-1:0] tbl_char;
  logic              is_release;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  assign is_release = s1_byte[REL_BIT];
  assign tbl_char   = shift_held ? shift_char(s1_byte[IDX_W-1:0])
                                 : plain_char(s1_byte[IDX_W-1:0]);

  always_comb begin
    shift_held_next     = shift_held;
    ctrl_held_next      = ctrl_held;
    prefix_pending_next = prefix_pending;
    kind_next           = KIND_NONE;
    char_next           = '0;
    if (s1_byte == SC_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (prefix_pending) begin
      prefix_pending_next = 1'b0;
      if (!is_release) begin
        kind_next = nav_kind(s1_byte);
      end
    end else if (s1_byte == SC_LSHIFT_MK || s1_byte == SC_RSHIFT_MK) begin
      shift_held_next = 1'b1;
    end else if (s1_byte == SC_LSHIFT_BR || s1_byte == SC_RSHIFT_BR) begin
      shift_held_next = 1'b0;
    end else if (s1_byte == SC_CTRL_MK) begin
      ctrl_held_next = 1'b1;
    end else if (s1_byte == SC_CTRL_BR) begin
      ctrl_held_next = 1'b0;
    end else if (s1_byte == SC_F1_MK) begin
      kind_next = KIND_F1;
    end else if (s1_byte == SC_F2_MK) begin
      kind_next = KIND_F2;
    end else if (!is_release && s1_byte < SC_TABLE_LEN) begin
      if (ctrl_held && tbl_char == ASCII_LC_C) begin
        kind_next = KIND_CTRLC;
      end else if (tbl_char != '0) begin
        kind_next = KIND_CHAR;
        char_next = tbl_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      shift_held     <= 1'b0;
      ctrl_held      <= 1'b0;
      prefix_pending <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid      <= 1'b1;
        shift_held     <= shift_held_next;
        ctrl_held      <= ctrl_held_next;
        prefix_pending <= prefix_pending_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= scan_byte;
    end
    if (s1_adv) begin
      key_kind  <= KIND_W'(kind_next);
      char_code <= char_next;
      ctrl_down <= ctrl_held_next;
    end
  end

  `PS2S1_ASSERT_IMPLY(a_char_zero, out_valid && key_kind != KIND_CHAR, char_code == '0)
  `PS2S1_ASSERT_IMPLY(a_ctrl_track, out_valid, ctrl_down == ctrl_held)
  `PS2S1_ASSERT_IMPLY(a_ctrlc_ctrl, out_valid && key_kind == KIND_CTRLC, ctrl_down)
  `PS2S1_ASSERT_NEXT(a_prefix_set, s1_adv && s1_byte == SC_PREFIX, prefix_pending)
  `PS2S1_ASSERT_IMPLY(a_ready_empty, !s1_valid, in_ready)

endmodule
